// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the header parser RTL.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ETHP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ETHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ethp_pkg.sv =====
// Shared types and constants for the Ethernet/IPv4/TCP header parser.
// No dependencies; used by ethp_parser, ethp_out_skid and the top level.
package ethp_pkg;

  localparam int unsigned PosW = 8;   // header offsets stay below 134
  localparam logic [PosW-1:0] PosMax = '1;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'h06;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;

  // Byte offsets within the frame
  localparam logic [PosW-1:0] OFS_SRC_MAC   = 8'd6;
  localparam logic [PosW-1:0] OFS_ETYPE     = 8'd12;
  localparam logic [PosW-1:0] OFS_ETYPE_LO  = 8'd13;
  localparam logic [PosW-1:0] OFS_IP        = 8'd14;
  localparam logic [PosW-1:0] OFS_TOTLEN_HI = 8'd16;
  localparam logic [PosW-1:0] OFS_TOTLEN_LO = 8'd17;
  localparam logic [PosW-1:0] OFS_PROTO     = 8'd23;
  localparam logic [PosW-1:0] OFS_SRC_IP    = 8'd26;
  localparam logic [PosW-1:0] OFS_DST_IP    = 8'd30;
  localparam logic [PosW-1:0] OFS_IP_END    = 8'd34;
  // Offsets within the TCP header
  localparam logic [PosW-1:0] TCP_DST_PORT  = 8'd2;
  localparam logic [PosW-1:0] TCP_PORTS_END = 8'd4;
  localparam logic [PosW-1:0] TCP_DOFF      = 8'd12;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_CHAR    = 1'b1;

  localparam int unsigned DataW = 216;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_length;
    logic [7:0]  payload_char;
    logic        last;
  } result_t;

  function automatic logic [3:0] at_least_five(logic [3:0] words);
    return (words < MIN_HDR_WORDS) ? MIN_HDR_WORDS : words;
  endfunction

  function automatic logic [7:0] filter_char(logic [7:0] b);
    logic keep;
    keep = (b >= CHAR_FIRST && b <= CHAR_LAST) || b == CHAR_LF || b == CHAR_CR;
    return keep ? b : CHAR_DOT;
  endfunction

endpackage

// ===== rtl/eth_ipv4_tcp_header_parser_top.sv =====
// Top level of the Ethernet/IPv4/TCP header parser: stream ports and packing.
// Depends on ethp_pkg, ethp_parser and ethp_out_skid.
//
// Takes one captured frame byte per beat and accepts a beat every clock cycle while s_axis_tready is high.
// Non-IPv4 and non-TCP frames produce nothing; otherwise one summary record
// (tuser = 0) is issued on the last TCP header byte, followed by one filtered
// character beat (tuser = 1) per payload byte; tlast marks the final record of
// the frame. Each byte is handled combinationally by the parser, and its
// result goes to the master side via a result register backed by one skid
// register, which absorbs output stalls: s_axis_tready drops only when both
// hold a beat, so with m_axis_tready high the block sustains one byte per
// cycle. There is no clearing pass after reset.
module eth_ipv4_tcp_header_parser_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] frame_byte
  input  logic                       s_axis_tlast,  // frame_end
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [47:0] dst_mac, [95:48] src_mac, [127:96] src_ip, [159:128] dst_ip,
  // [175:160] src_port, [191:176] dst_port, [207:192] payload_length,
  // [215:208] payload_char
  output logic [ethp_pkg::DataW-1:0] m_axis_tdata,
  output logic                       m_axis_tuser,  // [0] record_kind
  output logic                       m_axis_tlast   // last
);
  import ethp_pkg::*;

  logic    beat, res_valid;
  result_t res, out_res;

  assign beat = s_axis_tvalid && s_axis_tready;

  ethp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .frame_byte_i (s_axis_tdata),
    .frame_end_i  (s_axis_tlast),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ethp_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {out_res.payload_char, out_res.payload_length,
                         out_res.dst_port, out_res.src_port,
                         out_res.dst_ip, out_res.src_ip,
                         out_res.src_mac, out_res.dst_mac};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

// ===== rtl/ethp_parser.sv =====
// Frame parser: byte counter, header field capture and result formation.
// Depends on ethp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ethp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       frame_byte_i,
  input  logic             frame_end_i,
  output logic             res_valid_o,
  output ethp_pkg::result_t res_o
);
  import ethp_pkg::*;

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [47:0]     dst_mac_q, dst_mac_d, src_mac_q, src_mac_d;
  logic [15:0]     etype_q, etype_d;
  logic [3:0]      ihl_q, ihl_d, doff_q, doff_d;
  logic [15:0]     totlen_q, totlen_d;
  logic [31:0]     src_ip_q, src_ip_d, dst_ip_q, dst_ip_d;
  logic [15:0]     src_port_q, src_port_d, dst_port_q, dst_port_d;
  logic [15:0]     remain_q, remain_d;

  logic [PosW-1:0] tcp_start, rel;
  logic [6:0]      hdr_len;
  logic [15:0]     plen;

  assign hdr_len = {1'b0, ihl_q, 2'b00} + {1'b0, doff_q, 2'b00};
  assign plen    = (totlen_q > {9'd0, hdr_len}) ? (totlen_q - {9'd0, hdr_len}) : 16'd0;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    dst_mac_d  = dst_mac_q;
    src_mac_d  = src_mac_q;
    etype_d    = etype_q;
    ihl_d      = ihl_q;
    doff_d     = doff_q;
    totlen_d   = totlen_q;
    src_ip_d   = src_ip_q;
    dst_ip_d   = dst_ip_q;
    src_port_d = src_port_q;
    dst_port_d = dst_port_q;
    remain_d   = remain_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    tcp_start   = '0;
    rel         = '0;

    if (beat_i) begin
      case (phase_q)
        PH_HEADER: begin
          if (pos_q < OFS_SRC_MAC) begin
            dst_mac_d = {dst_mac_q[39:0], frame_byte_i};
          end else if (pos_q < OFS_ETYPE) begin
            src_mac_d = {src_mac_q[39:0], frame_byte_i};
          end else if (pos_q < OFS_IP) begin
            etype_d = {etype_q[7:0], frame_byte_i};
            if (pos_q == OFS_ETYPE_LO && etype_d != ETHERTYPE_IPV4) begin
              phase_d = PH_DISCARD;
            end
          end else begin
            if (pos_q == OFS_IP) begin
              ihl_d = at_least_five(frame_byte_i[3:0]);
            end else if (pos_q == OFS_TOTLEN_HI || pos_q == OFS_TOTLEN_LO) begin
              totlen_d = {totlen_q[7:0], frame_byte_i};
            end else if (pos_q == OFS_PROTO) begin
              if (frame_byte_i != PROTO_TCP) phase_d = PH_DISCARD;
            end else if (pos_q >= OFS_SRC_IP && pos_q < OFS_DST_IP) begin
              src_ip_d = {src_ip_q[23:0], frame_byte_i};
            end else if (pos_q >= OFS_DST_IP && pos_q < OFS_IP_END) begin
              dst_ip_d = {dst_ip_q[23:0], frame_byte_i};
            end
            // TCP header starts right after the (possibly padded) IP header
            tcp_start = OFS_IP + {2'b00, ihl_d, 2'b00};
            rel       = pos_q - tcp_start;
            if (phase_d == PH_HEADER && pos_q >= tcp_start) begin
              if (rel < TCP_DST_PORT) begin
                src_port_d = {src_port_q[7:0], frame_byte_i};
              end else if (rel < TCP_PORTS_END) begin
                dst_port_d = {dst_port_q[7:0], frame_byte_i};
              end else if (rel == TCP_DOFF) begin
                doff_d = at_least_five(frame_byte_i[7:4]);
              end else if (rel > TCP_DOFF && (rel + 8'd1) == {2'b00, doff_q, 2'b00}) begin
                // last TCP header byte: issue the summary record
                res_valid_o          = 1'b1;
                res_o.kind           = KIND_SUMMARY;
                res_o.dst_mac        = dst_mac_q;
                res_o.src_mac        = src_mac_q;
                res_o.src_ip         = src_ip_q;
                res_o.dst_ip         = dst_ip_q;
                res_o.src_port       = src_port_q;
                res_o.dst_port       = dst_port_q;
                res_o.payload_length = plen;
                res_o.last           = (plen == 16'd0) || frame_end_i;
                if (plen == 16'd0) begin
                  phase_d = PH_DISCARD;
                end else begin
                  remain_d = plen;
                  phase_d  = PH_PAYLOAD;
                end
              end
            end
          end
          if (pos_q != PosMax) pos_d = pos_q + PosW'(1);
        end
        PH_PAYLOAD: begin
          if (remain_q != 16'd0) remain_d = remain_q - 16'd1;
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_CHAR;
          res_o.payload_char = filter_char(frame_byte_i);
          res_o.last         = (remain_d == 16'd0) || frame_end_i;
          if (remain_d == 16'd0) phase_d = PH_DISCARD;
        end
        default: begin
          // drop everything up to the frame end
        end
      endcase

      if (frame_end_i) begin
        pos_d   = '0;
        phase_d = PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      ihl_q    <= '0;
      doff_q   <= '0;
      remain_q <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      ihl_q    <= ihl_d;
      doff_q   <= doff_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_mac_q  <= dst_mac_d;
    src_mac_q  <= src_mac_d;
    etype_q    <= etype_d;
    totlen_q   <= totlen_d;
    src_ip_q   <= src_ip_d;
    dst_ip_q   <= dst_ip_d;
    src_port_q <= src_port_d;
    dst_port_q <= dst_port_d;
  end

  `ETHP_ASSERT_IMPL(a_payload_remain, clk_i, rst_ni, phase_q == PH_PAYLOAD,
    remain_q != 16'd0, "payload phase with nothing left to emit")
  `ETHP_ASSERT_NEXT(a_end_restarts, clk_i, rst_ni, beat_i && frame_end_i,
    phase_q == PH_HEADER && pos_q == '0, "frame end did not restart header parse")

endmodule

// ===== rtl/ethp_out_skid.sv =====
// Result register plus skid register between the parser and the output port.
// Depends on ethp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ethp_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ethp_pkg::result_t data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ethp_pkg::result_t out_data_o
);
  import ethp_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    main_free;

  assign main_free   = !main_valid_q || out_ready_i;
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_free) begin
      // advance the skid beat first; no push can arrive while it is held
      main_valid_q <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      main_q <= skid_valid_q ? skid_q : data_i;
    end
    if (!main_free && push_i) begin
      skid_q <= data_i;
    end
  end

  `ETHP_ASSERT_IMPL(a_skid_behind_main, clk_i, rst_ni, skid_valid_q,
    main_valid_q, "skid register holds a beat while result register is empty")
  `ETHP_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_valid_q && out_ready_i,
    main_valid_q && !skid_valid_q, "skid beat not moved into result register")

endmodule
